FILE: hdl/scfp_pkg.sv
// Shared types and constants for the sequenced command frame parser.
// No dependencies. Every other file of the block but scfp_in_if uses this package.
package scfp_pkg;

  // Largest number of parameter bytes that one frame can carry.
  localparam int unsigned MaxParamBytes = 10;
  localparam int unsigned CountW        = 4;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_LOWEST_OP    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_HIGHEST_OP   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_RESET_OPCODE = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_TABLE_LOW    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_TABLE_HIGH   = 3'd4;

  // Result status codes.
  localparam logic [1:0] ST_ACCEPTED  = 2'd0;
  localparam logic [1:0] ST_REJECTED  = 2'd1;
  localparam logic [1:0] ST_MALFORMED = 2'd2;

  // Frame byte positions before the parameter bytes.
  localparam logic [CountW-1:0] POS_ID_HIGH = 4'd0;
  localparam logic [CountW-1:0] POS_ID_LOW  = 4'd1;
  localparam logic [CountW-1:0] POS_OPCODE  = 4'd2;
  localparam logic [CountW-1:0] POS_PARAMS  = 4'd3;

  typedef struct packed {
    logic [7:0]  lowest_op;
    logic [7:0]  highest_op;
    logic [7:0]  reset_opcode;
    logic [63:0] table_low;
    logic [63:0] table_high;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [15:0]       frame_id;
    logic [7:0]        frame_opcode;
    logic [CountW-1:0] param_count;
    logic [63:0]       params_front;
    logic [15:0]       params_back;
    logic [15:0]       last_good_id;
  } result_t;

endpackage

FILE: hdl/scfp_in_if.sv
// Input byte channel of the frame parser: valid/ready handshake plus one byte.
// Depends on nothing.
interface scfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: hdl/scfp_out_if.sv
// Result channel of the frame parser: valid/ready handshake plus the frame report.
// Depends on scfp_pkg for the parameter count width.
interface scfp_out_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 status;
  logic [15:0]                frame_id;
  logic [7:0]                 frame_opcode;
  logic [scfp_pkg::CountW-1:0] param_count;
  logic [63:0]                params_front;
  logic [15:0]                params_back;
  logic [15:0]                last_good_id;

  modport source (output valid, output status, output frame_id, output frame_opcode,
                  output param_count, output params_front, output params_back,
                  output last_good_id, input ready);
  modport sink   (input valid, input status, input frame_id, input frame_opcode,
                  input param_count, input params_front, input params_back,
                  input last_good_id, output ready);
endinterface

FILE: hdl/scfp_cfg_if.sv
// Configuration write channel of the frame parser: register index and data.
// Depends on scfp_pkg for the index width.
interface scfp_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [scfp_pkg::CfgIdxW-1:0] index;
  logic [63:0]                  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/sequenced_command_frame_parser_core.sv
// Top level of the sequenced command frame parser: byte input register,
// parser, result register. Depends on scfp_pkg, the three channel interfaces,
// scfp_cfg_regs and scfp_parser.
//
//   channel   role    payload                               purpose
//   in_chan   sink    rx_byte                               one received byte per item
//   out_chan  source  status, frame_id, frame_opcode,       one report per finished or
//                     param_count, params_front,            malformed frame
//                     params_back, last_good_id
//   cfg_chan  sink    index, data                           register writes, always ready
//
// A byte accepted into the input register is consumed when the parser
// advances, and any report it causes is loaded into the result register at
// that same edge and offered from there. The sustained rate is one byte per
// cycle while no stalled result holds the parser, set by the single parser
// stage. Reset (rst_n low at a clock edge) empties both registers, restores
// the register defaults and returns the parser to the first id byte. A
// stalled result holds the parser only when the byte in the input register
// would produce another result.
module sequenced_command_frame_parser_core (
  input  logic       clk,
  input  logic       rst_n,
  scfp_in_if.sink    in_chan,
  scfp_out_if.source out_chan,
  scfp_cfg_if.sink   cfg_chan
);
  import scfp_pkg::*;

  cfg_t    cfg;
  logic    in_valid_r;
  logic [7:0] in_byte_r;
  logic    out_valid_r;
  result_t out_res_r;
  logic    res_valid;
  result_t res;
  logic    advance;

  scfp_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .cfg      (cfg)
  );

  scfp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .step      (advance),
    .rx_byte   (in_byte_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // The held byte moves through the parser unless it makes a result and the
  // result register is still occupied by an untaken report.
  assign advance = in_valid_r && (!res_valid || !out_valid_r || out_chan.ready);

  // The input register refills whenever it is empty or draining this cycle.
  assign in_chan.ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      in_byte_r <= in_chan.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.status       = out_res_r.status;
  assign out_chan.frame_id     = out_res_r.frame_id;
  assign out_chan.frame_opcode = out_res_r.frame_opcode;
  assign out_chan.param_count  = out_res_r.param_count;
  assign out_chan.params_front = out_res_r.params_front;
  assign out_chan.params_back  = out_res_r.params_back;
  assign out_chan.last_good_id = out_res_r.last_good_id;

  // A malformed opcode report never carries parameter bytes.
  a_malformed_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.status == ST_MALFORMED) |->
      (out_res_r.param_count == '0 && out_res_r.params_front == '0 &&
       out_res_r.params_back == '0))
    else $error("malformed report carries parameter bytes");

  // An accepted frame becomes the last good id in the same report.
  a_accept_updates_id: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.status == ST_ACCEPTED) |->
      (out_res_r.last_good_id == out_res_r.frame_id))
    else $error("accepted frame did not update the last good id");

  // The reported parameter count never exceeds the byte store.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.param_count <= 4'(MaxParamBytes)))
    else $error("parameter count beyond the byte store");

  // A new report only ever comes from a byte held in the input register.
  a_report_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_valid_r))
    else $error("report produced without a byte in the input register");

endmodule

FILE: hdl/scfp_cfg_regs.sv
// Configuration register file of the frame parser.
// Depends on scfp_pkg and scfp_cfg_if.
module scfp_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  scfp_cfg_if.sink          cfg_chan,
  output scfp_pkg::cfg_t    cfg
);
  import scfp_pkg::*;

  cfg_t cfg_r;

  // Writes are always taken; unknown indexes are dropped.
  assign cfg_chan.ready = 1'b1;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lowest_op    <= 8'd0;
      cfg_r.highest_op   <= 8'd16;
      cfg_r.reset_opcode <= 8'd0;
      cfg_r.table_low    <= 64'd0;
      cfg_r.table_high   <= 64'd0;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        CFG_LOWEST_OP:    cfg_r.lowest_op    <= cfg_chan.data[7:0];
        CFG_HIGHEST_OP:   cfg_r.highest_op   <= cfg_chan.data[7:0];
        CFG_RESET_OPCODE: cfg_r.reset_opcode <= cfg_chan.data[7:0];
        CFG_TABLE_LOW:    cfg_r.table_low    <= cfg_chan.data;
        CFG_TABLE_HIGH:   cfg_r.table_high   <= cfg_chan.data;
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: hdl/scfp_parser.sv
// Frame assembly state, parameter byte store and result composition.
// Depends on scfp_pkg. Processes one byte per cycle when step is high.
module scfp_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  scfp_pkg::cfg_t    cfg,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  output logic              res_valid,
  output scfp_pkg::result_t res
);
  import scfp_pkg::*;

  logic [CountW-1:0] byte_count_r, byte_count_nxt;
  logic [15:0]       held_id_r, held_id_nxt;
  logic [7:0]        held_opcode_r, held_opcode_nxt;
  logic [15:0]       running_sum_r, running_sum_nxt;
  logic [7:0]        checksum_high_r, checksum_high_nxt;
  logic [15:0]       accepted_id_r, accepted_id_nxt;
  logic [CountW-1:0] param_len_r, param_len_nxt;
  logic [7:0]        param_store_r [MaxParamBytes];

  logic [CountW-1:0] param_end;
  logic [CountW-1:0] store_idx;
  logic              store_wr;
  logic [15:0]       sum_plus;
  logic              malformed;
  logic              frame_ok;
  logic [CountW-1:0] emit_count;
  logic [63:0]       front;
  logic [15:0]       back;
  logic [CountW-1:0] table_len;
  logic [1:0]        res_status;
  logic [7:0]        res_opcode;

  // Parameter length of an opcode: nibble of the 32-entry table, clamped.
  function automatic logic [CountW-1:0] lookup_len(input logic [7:0] op, input cfg_t c);
    logic [7:0] k;
    logic [3:0] n;
    k = op - c.lowest_op;
    n = 4'd0;
    if (k < 8'd16) begin
      n = c.table_low[{k[3:0], 2'b00} +: 4];
    end else if (k < 8'd32) begin
      n = c.table_high[{k[3:0], 2'b00} +: 4];
    end
    if (n > 4'(MaxParamBytes)) begin
      n = 4'(MaxParamBytes);
    end
    return n;
  endfunction

  assign param_end = POS_PARAMS + param_len_r;
  assign store_idx = byte_count_r - POS_PARAMS;
  assign sum_plus  = running_sum_r + {8'd0, rx_byte};
  assign malformed = (rx_byte < cfg.lowest_op) || (rx_byte > cfg.highest_op);
  assign table_len = lookup_len(rx_byte, cfg);

  // The reset frame passes unconditionally; otherwise id sequence then checksum.
  always_comb begin
    if (held_id_r == 16'd1 && held_opcode_r == cfg.reset_opcode) begin
      frame_ok = 1'b1;
    end else if (held_id_r != accepted_id_r + 16'd1) begin
      frame_ok = 1'b0;
    end else begin
      frame_ok = ({checksum_high_r, rx_byte} == running_sum_r);
    end
  end

  // The next state and the report are worked out for the held byte whether or
  // not it moves this cycle, so res_valid never depends on step; the registers
  // below only take the new values when step is high.
  always_comb begin
    byte_count_nxt    = byte_count_r;
    held_id_nxt       = held_id_r;
    held_opcode_nxt   = held_opcode_r;
    running_sum_nxt   = running_sum_r;
    checksum_high_nxt = checksum_high_r;
    accepted_id_nxt   = accepted_id_r;
    param_len_nxt     = param_len_r;
    store_wr          = 1'b0;
    res_valid         = 1'b0;
    res_status        = ST_ACCEPTED;
    res_opcode        = held_opcode_r;
    emit_count        = param_len_r;
    priority if (byte_count_r == POS_ID_HIGH) begin
      held_id_nxt     = {rx_byte, 8'd0};
      running_sum_nxt = {8'd0, rx_byte};
      byte_count_nxt  = POS_ID_LOW;
    end else if (byte_count_r == POS_ID_LOW) begin
      held_id_nxt     = {held_id_r[15:8], rx_byte};
      running_sum_nxt = sum_plus;
      byte_count_nxt  = POS_OPCODE;
    end else if (byte_count_r == POS_OPCODE) begin
      held_opcode_nxt = rx_byte;
      res_opcode      = rx_byte;
      if (malformed) begin
        res_valid      = 1'b1;
        res_status     = ST_MALFORMED;
        emit_count     = '0;
        byte_count_nxt = POS_ID_HIGH;
      end else begin
        param_len_nxt   = table_len;
        running_sum_nxt = sum_plus;
        byte_count_nxt  = POS_PARAMS;
      end
    end else if (byte_count_r < param_end) begin
      store_wr        = 1'b1;
      running_sum_nxt = sum_plus;
      byte_count_nxt  = byte_count_r + 4'd1;
    end else if (byte_count_r == param_end) begin
      checksum_high_nxt = rx_byte;
      byte_count_nxt    = byte_count_r + 4'd1;
    end else begin
      res_valid      = 1'b1;
      res_status     = frame_ok ? ST_ACCEPTED : ST_REJECTED;
      byte_count_nxt = POS_ID_HIGH;
      if (frame_ok) begin
        accepted_id_nxt = held_id_r;
      end
    end
  end

  // Parameter bytes at or beyond the count read as zero.
  always_comb begin
    front = '0;
    back  = '0;
    for (int i = 0; i < MaxParamBytes; i++) begin
      if (4'(i) < emit_count) begin
        if (i < 8) begin
          front[(63 - 8 * i) -: 8] = param_store_r[i];
        end else if (i < 10) begin
          back[(15 - 8 * (i - 8)) -: 8] = param_store_r[i];
        end
      end
    end
  end

  assign res.status       = res_status;
  assign res.frame_id     = held_id_r;
  assign res.frame_opcode = res_opcode;
  assign res.param_count  = emit_count;
  assign res.params_front = front;
  assign res.params_back  = back;
  assign res.last_good_id = accepted_id_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r    <= '0;
      held_id_r       <= '0;
      held_opcode_r   <= '0;
      running_sum_r   <= '0;
      checksum_high_r <= '0;
      accepted_id_r   <= '0;
      param_len_r     <= '0;
    end else if (step) begin
      byte_count_r    <= byte_count_nxt;
      held_id_r       <= held_id_nxt;
      held_opcode_r   <= held_opcode_nxt;
      running_sum_r   <= running_sum_nxt;
      checksum_high_r <= checksum_high_nxt;
      accepted_id_r   <= accepted_id_nxt;
      param_len_r     <= param_len_nxt;
    end
  end

  // Byte store has no reset; entries are written before they are shown.
  always_ff @(posedge clk) begin
    if (step && store_wr) begin
      param_store_r[store_idx] <= rx_byte;
    end
  end

endmodule

FILE: bench/scfp_frame_check_pkg.sv
// Frame report tracker for the sequenced command frame parser bench: predicts
// the reports due from the received bytes and checks the reports that come back.
// Depends on scfp_pkg for the register indexes, status codes and structs.
package scfp_frame_check_pkg;
  import scfp_pkg::*;

  class frame_report_tracker;
    cfg_t              regs;
    logic [CountW-1:0] pos;
    logic [15:0]       id_hold;
    logic [15:0]       sum;
    logic [15:0]       good_id;
    logic [7:0]        op_hold;
    logic [7:0]        sum_high;
    logic [7:0]        param_buf [MaxParamBytes];
    int unsigned       plen;
    result_t           due [$];
    int unsigned       errors, bytes_in, reports, writes;
    int unsigned       accepted_n, rejected_n, malformed_n;

    function new();
      regs = '{lowest_op: 8'h00, highest_op: 8'h10, reset_opcode: 8'h00,
               table_low: 64'h0, table_high: 64'h0};
      pos = POS_ID_HIGH;
      id_hold = '0;
      sum = '0;
      good_id = '0;
      op_hold = '0;
      sum_high = '0;
      plen = 0;
      foreach (param_buf[i]) param_buf[i] = '0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [63:0] value);
      case (idx)
        CFG_LOWEST_OP:    regs.lowest_op = value[7:0];
        CFG_HIGHEST_OP:   regs.highest_op = value[7:0];
        CFG_RESET_OPCODE: regs.reset_opcode = value[7:0];
        CFG_TABLE_LOW:    regs.table_low = value;
        CFG_TABLE_HIGH:   regs.table_high = value;
        default: ;
      endcase
      writes++;
    endfunction

    // Parameter length of a valid opcode: a nibble picked by the distance from
    // the lowest opcode, clamped, and zero beyond the two table words.
    function int unsigned param_bytes(logic [7:0] op);
      logic [7:0] offs;
      logic [3:0] nib;
      offs = op - regs.lowest_op;
      if (offs < 16) nib = regs.table_low[4 * int'(offs) +: 4];
      else if (offs < 32) nib = regs.table_high[4 * (int'(offs) - 16) +: 4];
      else nib = '0;
      return (nib > MaxParamBytes) ? MaxParamBytes : 32'(nib);
    endfunction

    function result_t report(logic [1:0] status, int unsigned count);
      result_t r;
      r.status = status;
      r.frame_id = id_hold;
      r.frame_opcode = op_hold;
      r.param_count = CountW'(count);
      r.params_front = '0;
      r.params_back = '0;
      for (int i = 0; i < int'(count); i++) begin
        if (i < 8) r.params_front[63 - 8 * i -: 8] = param_buf[i];
        else r.params_back[15 - 8 * (i - 8) -: 8] = param_buf[i];
      end
      r.last_good_id = good_id;
      return r;
    endfunction

    function void note_byte(logic [7:0] b);
      bit ok;
      bytes_in++;
      case (pos)
        POS_ID_HIGH: begin
          id_hold = {b, 8'h00};
          sum = {8'h00, b};
          pos = POS_ID_LOW;
        end
        POS_ID_LOW: begin
          id_hold[7:0] = b;
          sum = sum + {8'h00, b};
          pos = POS_OPCODE;
        end
        POS_OPCODE: begin
          op_hold = b;
          if (b < regs.lowest_op || b > regs.highest_op) begin
            due.push_back(report(ST_MALFORMED, 0));
            pos = POS_ID_HIGH;
          end else begin
            plen = param_bytes(b);
            sum = sum + {8'h00, b};
            pos = POS_PARAMS;
          end
        end
        default: begin
          if (pos < POS_PARAMS + plen) begin
            param_buf[pos - POS_PARAMS] = b;
            sum = sum + {8'h00, b};
            pos = pos + 1'b1;
          end else if (pos == POS_PARAMS + plen) begin
            sum_high = b;
            pos = pos + 1'b1;
          end else begin
            if (id_hold == 16'h0001 && op_hold == regs.reset_opcode) ok = 1'b1;
            else if (id_hold != 16'(good_id + 16'd1)) ok = 1'b0;
            else ok = ({sum_high, b} == sum);
            if (ok) good_id = id_hold;
            due.push_back(report(ok ? ST_ACCEPTED : ST_REJECTED, plen));
            pos = POS_ID_HIGH;
          end
        end
      endcase
    endfunction

    function void same(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s expected %h got %h", $time, field, want, got);
      end
    endfunction

    function void check_report(result_t got);
      result_t want;
      reports++;
      if (due.size() == 0) begin
        errors++;
        $display("%0t: report with nothing due, status %0d id %h", $time, got.status,
                 got.frame_id);
        return;
      end
      want = due.pop_front();
      case (want.status)
        ST_ACCEPTED: accepted_n++;
        ST_REJECTED: rejected_n++;
        default:     malformed_n++;
      endcase
      same("status", 64'(want.status), 64'(got.status));
      same("frame_id", 64'(want.frame_id), 64'(got.frame_id));
      same("frame_opcode", 64'(want.frame_opcode), 64'(got.frame_opcode));
      same("param_count", 64'(want.param_count), 64'(got.param_count));
      same("params_front", want.params_front, got.params_front);
      same("params_back", 64'(want.params_back), 64'(got.params_back));
      same("last_good_id", 64'(want.last_good_id), 64'(got.last_good_id));
    endfunction

    function int unsigned pending();
      return due.size();
    endfunction
  endclass

endpackage

FILE: bench/tb_sequenced_command_frame_parser_core.sv
// Self-checking bench for sequenced_command_frame_parser_core: feeds byte
// streams of framed commands under many register settings and checks every report.
// Depends on scfp_pkg, the three channel interfaces and scfp_frame_check_pkg.
module tb_sequenced_command_frame_parser_core;
  import scfp_pkg::*;
  import scfp_frame_check_pkg::*;

  localparam int unsigned PhaseCount     = 10;
  localparam int unsigned PhaseItems     = 102;
  localparam int unsigned SettleCycles   = 6;
  localparam int unsigned DrainCycles    = 10;
  localparam int unsigned LongHoldCycles = 80;
  localparam int unsigned WatchdogLimit  = 2000;

  logic clk;
  logic rst_n;

  scfp_in_if  in_chan ();
  scfp_out_if out_chan ();
  scfp_cfg_if cfg_chan ();

  sequenced_command_frame_parser_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  frame_report_tracker tracker = new();

  // Bytes built but not yet offered. A frame may stay half sent across a
  // register change, which is how writes in mid-frame get exercised.
  logic [7:0]  tx_bytes [$];
  bit          send_quiet;
  bit          take_quiet;
  bit          long_hold_req;
  int unsigned idle_count = 0;

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Each side waits a random gap before each item, but now and then switches into a
  // quiet stretch in which it never waits, until it switches back.
  function automatic int unsigned draw_gap(inout bit quiet);
    if ($urandom_range(0, 19) == 0) quiet = !quiet;
    return quiet ? 0 : $urandom_range(0, 4);
  endfunction

  // Parameter bytes lean toward the two extremes.
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic cfg_t make_cfg(logic [7:0] lo, logic [7:0] hi, logic [7:0] rst_op,
                                    logic [63:0] tbl_lo, logic [63:0] tbl_hi);
    cfg_t c;
    c.lowest_op = lo;
    c.highest_op = hi;
    c.reset_opcode = rst_op;
    c.table_low = tbl_lo;
    c.table_high = tbl_hi;
    return c;
  endfunction

  function automatic cfg_t random_cfg();
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] rst_op;
    lo = 8'($urandom_range(0, 255));
    hi = (lo > 8'd210) ? 8'hFF : 8'(lo + $urandom_range(0, 45));
    rst_op = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(lo, hi)) : 8'($urandom);
    return make_cfg(lo, hi, rst_op, {$urandom, $urandom}, {$urandom, $urandom});
  endfunction

  // Valid opcodes mostly fall within the 32 entries that the length table
  // covers, so that the parameter lengths actually vary.
  function automatic logic [7:0] pick_valid_opcode();
    int unsigned lo;
    int unsigned hi;
    int unsigned span;
    lo = tracker.regs.lowest_op;
    hi = tracker.regs.highest_op;
    if (lo > hi) return 8'($urandom);
    span = hi - lo;
    if ($urandom_range(0, 3) != 0 && span > 31) span = 31;
    return 8'(lo + $urandom_range(0, span));
  endfunction

  function automatic logic [7:0] pick_bad_opcode();
    int unsigned lo;
    int unsigned hi;
    lo = tracker.regs.lowest_op;
    hi = tracker.regs.highest_op;
    if (lo > hi) return 8'($urandom);
    if (lo == 0 && hi == 255) return pick_valid_opcode();
    if (lo > 0 && (hi == 255 || $urandom_range(0, 1) == 0))
      return 8'($urandom_range(0, lo - 1));
    return 8'($urandom_range(hi + 1, 255));
  endfunction

  // Queues one frame. An opcode out of range ends the frame on the spot, so
  // nothing follows it. Otherwise the parameter count comes from the current
  // table and the checksum is the byte sum, flipped in some bits if asked.
  function automatic void push_frame(logic [15:0] id, logic [7:0] op, bit corrupt);
    logic [15:0] sum;
    logic [7:0]  b;
    tx_bytes.push_back(id[15:8]);
    tx_bytes.push_back(id[7:0]);
    tx_bytes.push_back(op);
    if (op < tracker.regs.lowest_op || op > tracker.regs.highest_op) return;
    sum = {8'h00, id[15:8]} + {8'h00, id[7:0]} + {8'h00, op};
    repeat (tracker.param_bytes(op)) begin
      b = rand_byte();
      tx_bytes.push_back(b);
      sum = sum + {8'h00, b};
    end
    if (corrupt) sum = sum ^ 16'($urandom_range(1, 65535));
    tx_bytes.push_back(sum[15:8]);
    tx_bytes.push_back(sum[7:0]);
  endfunction

  // Mostly well-formed frames in sequence, so that the id chain keeps moving
  // and frames get accepted; the rest are reset frames, wrong ids, wrong
  // checksums, bad opcodes, cut-off frames and loose bytes. When the parser
  // is out of step after noise, loose bytes are sent until it finishes the
  // frame it thinks it is in.
  function automatic void build_next();
    int unsigned r;
    logic [15:0] next_id;
    r = $urandom_range(0, 99);
    next_id = tracker.good_id + 16'd1;
    if (tracker.pos != POS_ID_HIGH || r < 4) begin
      repeat ($urandom_range(1, 3)) tx_bytes.push_back(8'($urandom));
    end else if (r < 8) begin
      push_frame(next_id, pick_valid_opcode(), 1'b0);
      repeat ($urandom_range(1, 2)) void'(tx_bytes.pop_back());
    end else if (r < 16) begin
      push_frame(next_id, pick_bad_opcode(), 1'b0);
    end else if (r < 22) begin
      push_frame(16'h0001, tracker.regs.reset_opcode, 1'($urandom_range(0, 1)));
    end else if (r < 30) begin
      push_frame(next_id + 16'($urandom_range(1, 65535)), pick_valid_opcode(), 1'b0);
    end else if (r < 38) begin
      push_frame(next_id, pick_valid_opcode(), 1'b1);
    end else begin
      push_frame(next_id, pick_valid_opcode(), 1'b0);
    end
  endfunction

  // Offers one byte after a random gap and notes it once it is taken. The
  // valid stays high on return, so back-to-back bytes never drop it.
  task automatic send_byte(input logic [7:0] value);
    int unsigned gap;
    gap = draw_gap(send_quiet);
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.rx_byte <= value;
    do @(posedge clk); while (!in_chan.ready);
    tracker.note_byte(value);
  endtask

  task automatic send_next();
    if (tx_bytes.size() == 0) build_next();
    send_byte(tx_bytes.pop_front());
  endtask

  // Stops offering bytes, waits for every due report, then waits out the extra
  // cycles it is given for bytes that are still in flight but cause no report.
  task automatic settle(input int unsigned extra);
    in_chan.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // Writes all five registers back to back; valid drops only after the last.
  task automatic write_config(input cfg_t c);
    logic [CfgIdxW-1:0] order [5];
    logic [63:0]        value;
    order = '{CFG_LOWEST_OP, CFG_HIGHEST_OP, CFG_RESET_OPCODE, CFG_TABLE_LOW,
              CFG_TABLE_HIGH};
    foreach (order[i]) begin
      case (order[i])
        CFG_LOWEST_OP:    value = {56'h0, c.lowest_op};
        CFG_HIGHEST_OP:   value = {56'h0, c.highest_op};
        CFG_RESET_OPCODE: value = {56'h0, c.reset_opcode};
        CFG_TABLE_LOW:    value = c.table_low;
        CFG_TABLE_HIGH:   value = c.table_high;
        default:          value = '0;
      endcase
      cfg_chan.valid <= 1'b1;
      cfg_chan.index <= order[i];
      cfg_chan.data <= value;
      do @(posedge clk); while (!cfg_chan.ready);
      tracker.write_reg(order[i], value);
    end
    cfg_chan.valid <= 1'b0;
  endtask

  // Report side. Each report gets a random stall first; on request it holds
  // ready low for a long stretch so that the block backs up into its input.
  initial begin
    result_t     got;
    int unsigned gap;
    out_chan.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (long_hold_req) begin
        out_chan.ready <= 1'b0;
        repeat (LongHoldCycles) @(posedge clk);
        long_hold_req = 1'b0;
      end
      gap = draw_gap(take_quiet);
      if (gap != 0) begin
        out_chan.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
      got.status = out_chan.status;
      got.frame_id = out_chan.frame_id;
      got.frame_opcode = out_chan.frame_opcode;
      got.param_count = out_chan.param_count;
      got.params_front = out_chan.params_front;
      got.params_back = out_chan.params_back;
      got.last_good_id = out_chan.last_good_id;
      tracker.check_report(got);
    end
  end

  // The run ends as a failure when no channel has moved an item for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
        (cfg_chan.valid && cfg_chan.ready)) begin
      idle_count <= 0;
    end else begin
      idle_count <= idle_count + 1;
    end
    if (idle_count == WatchdogLimit) begin
      $display("%0t: no item moved for %0d cycles, %0d reports still due", $time,
               WatchdogLimit, tracker.pending());
      $display("tb_sequenced_command_frame_parser_core failed");
      $finish;
    end
  end

  initial begin
    cfg_t        c;
    int unsigned guard;
    rst_n <= 1'b0;
    in_chan.valid <= 1'b0;
    in_chan.rx_byte <= '0;
    cfg_chan.valid <= 1'b0;
    cfg_chan.index <= CFG_LOWEST_OP;
    cfg_chan.data <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames under the reset settings (opcodes 0..16, no parameters).
    // The reset frame passes despite a bad checksum and sets the chain to 1.
    push_frame(16'h0001, 8'h00, 1'b1);
    // Next id with the highest valid opcode and a good checksum.
    push_frame(16'h0002, 8'h10, 1'b0);
    // Opcode above the range: reported as malformed after three bytes.
    push_frame(16'hFFFF, 8'hFF, 1'b0);
    // Right id, wrong checksum.
    push_frame(16'h0003, 8'h05, 1'b1);
    // Good checksum but an id off the chain.
    push_frame(16'hFFFF, 8'h00, 1'b0);
    // Chain resumes at the lowest opcode.
    push_frame(16'h0003, 8'h00, 1'b0);
    while (tx_bytes.size() != 0) send_byte(tx_bytes.pop_front());

    // Register settings, from the extremes to random ranges. Writes only go
    // in once the block has gone quiet; each setting with an ordered opcode range
    // ends with a frame left open past its opcode, so the next write lands mid-frame.
    for (int phase = 1; phase <= PhaseCount; phase++) begin
      settle(SettleCycles);
      case (phase)
        // Every opcode valid; most lie beyond the table and carry nothing.
        1: c = make_cfg(8'h00, 8'hFF, 8'hFF, {$urandom, $urandom}, {$urandom, $urandom});
        // Low table all ones: every such entry clamps to ten bytes.
        2: c = make_cfg(8'h40, 8'h5F, 8'h41, 64'hFFFF_FFFF_FFFF_FFFF, {$urandom, $urandom});
        // One valid opcode at the top with the full ten parameter bytes.
        3: c = make_cfg(8'hFF, 8'hFF, 8'hFF, 64'h0000_0000_0000_000A, 64'h0);
        // Range inverted: every opcode is malformed.
        4: c = make_cfg(8'h80, 8'h10, 8'h80, 64'hFFFF_FFFF_FFFF_FFFF,
                        64'hFFFF_FFFF_FFFF_FFFF);
        // Only opcode zero is valid.
        5: c = make_cfg(8'h00, 8'h00, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
        default: c = random_cfg();
      endcase
      write_config(c);
      // Back-pressure: the report side stalls for a long stretch while bytes
      // keep coming, so the block fills and stops taking input.
      if (phase == 1 || phase == 6) long_hold_req = 1'b1;
      for (int n = 0; n < PhaseItems; n++) send_next();
      guard = 0;
      if (c.lowest_op <= c.highest_op) begin
        while (tracker.pos < POS_PARAMS && guard < 40) begin
          send_next();
          guard++;
        end
      end
    end
    while (tx_bytes.size() != 0) send_byte(tx_bytes.pop_front());
    settle(DrainCycles);

    $display("Covered %0d bytes under %0d register settings (%0d writes): %0d reports,",
             tracker.bytes_in, PhaseCount + 1, tracker.writes, tracker.reports);
    $display("  %0d accepted, %0d rejected, %0d malformed, with stalls and mid-frame writes.",
             tracker.accepted_n, tracker.rejected_n, tracker.malformed_n);
    if (tracker.errors == 0) begin
      $display("tb_sequenced_command_frame_parser_core passed");
    end else begin
      $display("tb_sequenced_command_frame_parser_core failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/scfp_pkg.sv
hdl/scfp_in_if.sv
hdl/scfp_out_if.sv
hdl/scfp_cfg_if.sv
hdl/scfp_cfg_regs.sv
hdl/scfp_parser.sv
hdl/sequenced_command_frame_parser_core.sv
bench/scfp_frame_check_pkg.sv
bench/tb_sequenced_command_frame_parser_core.sv
